FILE: hw/rtl/slmd_pkg.sv
// Package for the sorted list merge block: sequencer states, action and
// list codes, and the data width. No dependencies.
package slmd_pkg;

  localparam int unsigned DATA_W = 32;

  // Input action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_MERGE = 1'b1;

  // Load target codes.
  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_MERGE
  } slmd_state_t;

endpackage

FILE: hw/rtl/sorted_list_merge_dedup_equal_top.sv
// Top level of the sorted list merge block: two list buffers, a merge
// sequencer around one shared signed comparator, and the result register.
// Depends on slmd_pkg.

// Loads append one signed element to list A or list B; a load into a
// full list is dropped and flagged on the next merge. A merge transaction
// walks both list heads, one result per cycle while the receiver does not
// hold back a waiting result: each cycle reads one entry of each list and
// compares the two heads in a single signed comparator. Both lists empty
// give a single empty-marked result. The input is not ready during a
// merge. Equal heads of the two lists give one result. The final
// result of a run carries last, and the run empties both lists and clears
// the overflow flag. List storage powers up undefined and needs no clearing.
module sorted_list_merge_dedup_equal_top
  import slmd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic                     in_list_sel,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_merged_value,
  output logic                     out_last,
  output logic                     out_empty_res,
  output logic                     out_overflow
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // List buffers.
  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  slmd_state_t state_r, state_nxt;
  logic [CW-1:0] count_a_r, count_a_nxt;
  logic [CW-1:0] count_b_r, count_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic          ovf_r, ovf_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic                     out_empty_r;
  logic                     out_ovf_r;

  logic                     in_fire;
  logic                     wr_a;
  logic                     wr_b;
  logic                     out_free;
  logic                     emit;
  logic                     has_a;
  logic                     has_b;
  logic signed [DATA_W-1:0] head_a;
  logic signed [DATA_W-1:0] head_b;
  logic                     a_lt_b;
  logic                     a_eq_b;
  logic                     take_a;
  logic                     take_b;
  logic signed [DATA_W-1:0] res_value;
  logic                     res_last;
  logic                     res_empty;

  // The input is open only while no merge runs.
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Heads of both lists; the shared comparator orders them.
  assign has_a  = ia_r < count_a_r;
  assign has_b  = ib_r < count_b_r;
  assign head_a = $signed(mem_a[ia_r[IW-1:0]]);
  assign head_b = $signed(mem_b[ib_r[IW-1:0]]);
  assign a_lt_b = head_a < head_b;
  assign a_eq_b = head_a == head_b;

  // Pick which lists advance for the current result.
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    priority if (has_a && has_b) begin
      take_a = a_lt_b || a_eq_b;
      take_b = !a_lt_b;
    end else if (has_a) begin
      take_a = 1'b1;
    end else if (has_b) begin
      take_b = 1'b1;
    end else begin
      take_a = 1'b0;
      take_b = 1'b0;
    end
  end

  assign res_empty = !has_a && !has_b;
  assign res_value = take_a ? head_a : (take_b ? head_b : '0);
  assign ia_nxt    = take_a ? ia_r + CW'(1) : ia_r;
  assign ib_nxt    = take_b ? ib_r + CW'(1) : ib_r;
  assign res_last  = res_empty || ((ia_nxt >= count_a_r) && (ib_nxt >= count_b_r));

  // Sequencer: next state and control.
  always_comb begin
    state_nxt   = state_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    ovf_nxt     = ovf_r;
    emit        = 1'b0;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_MERGE) begin
            state_nxt = S_MERGE;
          end else if (in_list_sel == LIST_A) begin
            if (count_a_r < CW'(DEPTH)) begin
              wr_a        = 1'b1;
              count_a_nxt = count_a_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (count_b_r < CW'(DEPTH)) begin
              wr_b        = 1'b1;
              count_b_nxt = count_b_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      S_MERGE: begin
        if (out_free) begin
          emit = 1'b1;
          if (res_last) begin
            state_nxt   = S_IDLE;
            count_a_nxt = '0;
            count_b_nxt = '0;
            ovf_nxt     = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      ovf_r     <= ovf_nxt;
      if (emit) begin
        ia_r        <= res_last ? '0 : ia_nxt;
        ib_r        <= res_last ? '0 : ib_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= res_value;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
      out_ovf_r   <= ovf_r;
    end
  end

  // List buffer writes.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a_r[IW-1:0]] <= in_value;
    end
    if (wr_b) begin
      mem_b[count_b_r[IW-1:0]] <= in_value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_empty_res    = out_empty_r;
  assign out_overflow     = out_ovf_r;

`ifndef NO_ASSERTIONS
  // Fill counts never pass the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(DEPTH)) && (count_b_r <= CW'(DEPTH)))
    else $error("list count exceeds depth");

  // No input is taken while a merge runs.
  a_busy_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> !in_ready)
    else $error("input ready during merge");

  // An empty-marked result is always the last of its run.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> out_last)
    else $error("empty result not marked last");

  // The final result of a run leaves both lists empty and the flag clear.
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res_last) |=> (count_a_r == '0) && (count_b_r == '0) && !ovf_r)
    else $error("merge did not clear list state");
`endif

endmodule

FILE: sim/sorted_list_merge_dedup_equal_top_tb.sv
// Self-checking testbench for sorted_list_merge_dedup_equal_top: a directed table, then
// random load and merge sessions, each checked against an in-bench merge predictor.
// Depends on slmd_pkg and the top level under test.
`timescale 1ns / 1ps

module sorted_list_merge_dedup_equal_top_tb;
  import slmd_pkg::*;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 170;
  localparam int END_WAIT = 20;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  // How the values of one random session are generated.
  localparam int MODE_NARROW = 0;
  localparam int MODE_WIDE = 1;
  localparam int MODE_EXTREME = 2;
  localparam int MODE_SCRAMBLED = 3;

  // Receiver stall patterns.
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_EVERY_THIRD = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     empty;
    logic                     ovf;
  } merge_res_t;

  // One row of the directed table; a row with a typed result is a merge of one result.
  typedef struct packed {
    logic                     act;
    logic                     sel;
    logic signed [DATA_W-1:0] val;
    int                       rep;
    bit                       typed;
    merge_res_t               res;
  } stim_row_t;

  localparam int DIR_ROWS = 15;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // Merge right after reset with both lists empty.
    '{ACT_MERGE, LIST_A, 32'sd0, 1, 1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
    // Most negative value alone in list A; the merge ignores its own fields.
    '{ACT_LOAD, LIST_A, 32'sh8000_0000, 1, 1'b0, '0},
    '{ACT_MERGE, LIST_B, -32'sd1, 1, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0, 1'b0}},
    // Most positive value alone in list B.
    '{ACT_LOAD, LIST_B, 32'sh7FFF_FFFF, 1, 1'b0, '0},
    '{ACT_MERGE, LIST_A, 32'sd0, 1, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
    // Equal heads collapse into one result.
    '{ACT_LOAD, LIST_A, 32'sd7, 1, 1'b0, '0},
    '{ACT_LOAD, LIST_B, 32'sd7, 1, 1'b0, '0},
    '{ACT_MERGE, LIST_B, 32'sd0, 1, 1'b1, '{32'sd7, 1'b1, 1'b0, 1'b0}},
    // List B filled past its depth with duplicates while list A stays empty.
    '{ACT_LOAD, LIST_B, -32'sd5, DEPTH + 1, 1'b0, '0},
    '{ACT_MERGE, LIST_A, 32'sd0, 1, 1'b0, '0},
    // Unsorted list A against a single element in list B.
    '{ACT_LOAD, LIST_A, 32'sd9, 1, 1'b0, '0},
    '{ACT_LOAD, LIST_A, 32'sd2, 1, 1'b0, '0},
    '{ACT_LOAD, LIST_B, 32'sd4, 1, 1'b0, '0},
    '{ACT_MERGE, LIST_A, 32'sd0, 1, 1'b0, '0},
    // The previous merge emptied the lists and cleared the overflow flag.
    '{ACT_MERGE, LIST_B, 32'sd0, 1, 1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_action = ACT_LOAD;
  logic                     in_list_sel = LIST_A;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_merged_value;
  logic                     out_last;
  logic                     out_empty_res;
  logic                     out_overflow;

  // Predictor state: the two list buffers, their fill counts and the dropped-load flag.
  logic signed [DATA_W-1:0] lst_a [DEPTH];
  logic signed [DATA_W-1:0] lst_b [DEPTH];
  int                       cnt_a = 0;
  int                       cnt_b = 0;
  logic                     ovf_seen = 1'b0;

  merge_res_t merged_expect_q [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         rx_mode = RX_ALWAYS;
  int         rx_left = 0;
  int         rx_phase = 0;

  sorted_list_merge_dedup_equal_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_list_sel      (in_list_sel),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res),
    .out_overflow     (out_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Updates the list state for one accepted transaction and queues the merge results.
  task automatic predict_merge(input logic act, input logic sel,
                               input logic signed [DATA_W-1:0] val);
    int                       ia;
    int                       ib;
    logic signed [DATA_W-1:0] v;
    merge_res_t               r;
    ia = 0;
    ib = 0;
    if (act == ACT_LOAD) begin
      if (sel == LIST_A) begin
        if (cnt_a < DEPTH) begin
          lst_a[cnt_a] = val;
          cnt_a++;
        end else begin
          ovf_seen = 1'b1;
        end
      end else begin
        if (cnt_b < DEPTH) begin
          lst_b[cnt_b] = val;
          cnt_b++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
    end else if (cnt_a == 0 && cnt_b == 0) begin
      r.value = '0;
      r.last = 1'b1;
      r.empty = 1'b1;
      r.ovf = ovf_seen;
      merged_expect_q.push_back(r);
      ovf_seen = 1'b0;
    end else begin
      // Walk both heads; the smaller one goes out, equal heads go out once.
      while (ia < cnt_a || ib < cnt_b) begin
        if (ia < cnt_a && ib < cnt_b) begin
          if (lst_a[ia] == lst_b[ib]) begin
            v = lst_a[ia];
            ia++;
            ib++;
          end else if (lst_a[ia] < lst_b[ib]) begin
            v = lst_a[ia];
            ia++;
          end else begin
            v = lst_b[ib];
            ib++;
          end
        end else if (ia < cnt_a) begin
          v = lst_a[ia];
          ia++;
        end else begin
          v = lst_b[ib];
          ib++;
        end
        r.value = v;
        r.last = (ia >= cnt_a && ib >= cnt_b);
        r.empty = 1'b0;
        r.ovf = ovf_seen;
        merged_expect_q.push_back(r);
      end
      cnt_a = 0;
      cnt_b = 0;
      ovf_seen = 1'b0;
    end
  endtask

  // Drives one transaction in bursts with random gaps and waits for its acceptance.
  // A typed result replaces the predicted ones for that transaction.
  task automatic send_item(input logic act, input logic sel,
                           input logic signed [DATA_W-1:0] val,
                           input bit typed, input merge_res_t typed_res);
    int gap;
    int base;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_list_sel <= sel;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    base = merged_expect_q.size();
    predict_merge(act, sel, val);
    if (typed) begin
      while (merged_expect_q.size() > base) void'(merged_expect_q.pop_back());
      merged_expect_q.push_back(typed_res);
    end
    items_sent++;
  endtask

  // Next element of a generated list; all modes but the scrambled one never go down.
  function automatic longint next_elem(input int mode, input longint prev, input bit first);
    longint v;
    case (mode)
      MODE_NARROW: begin
        v = first ? longint'($urandom_range(0, 12)) - 20 : prev + longint'($urandom_range(0, 3));
      end
      MODE_WIDE: begin
        v = first ? VAL_MIN + longint'($urandom_range(0, 32'h7FFF_FFFF))
                  : prev + longint'($urandom % 400_000_000);
      end
      MODE_EXTREME: begin
        if (first) begin
          v = VAL_MIN + longint'($urandom_range(0, 1) * $urandom_range(0, 2));
        end else begin
          case ($urandom_range(0, 3))
            0: v = prev;
            1: v = prev + 1;
            2: v = VAL_MAX;
            default: v = prev + (VAL_MAX - prev) / 2;
          endcase
        end
      end
      default: begin
        v = longint'(int'($urandom));
      end
    endcase
    if (v > VAL_MAX) v = VAL_MAX;
    return v;
  endfunction

  // One random session: build two lists, load them interleaved, then usually merge.
  task automatic run_session();
    int                       pick;
    int                       mode;
    int                       na;
    int                       nb;
    int                       ia;
    int                       ib;
    longint                   prev;
    bit                       take_a;
    logic signed [DATA_W-1:0] la [DEPTH + 2];
    logic signed [DATA_W-1:0] lb [DEPTH + 2];
    pick = $urandom_range(0, 9);
    if (pick < 5) mode = MODE_NARROW;
    else if (pick < 7) mode = MODE_WIDE;
    else if (pick < 9) mode = MODE_EXTREME;
    else mode = MODE_SCRAMBLED;
    na = ($urandom_range(0, 4) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2) : $urandom_range(0, 6);
    nb = ($urandom_range(0, 4) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2) : $urandom_range(0, 6);
    prev = 0;
    for (int k = 0; k < na; k++) begin
      prev = next_elem(mode, prev, k == 0);
      la[k] = prev[DATA_W-1:0];
    end
    for (int k = 0; k < nb; k++) begin
      prev = next_elem(mode, prev, k == 0);
      lb[k] = prev[DATA_W-1:0];
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      take_a = (ib == nb) || (ia < na && $urandom_range(0, 1) == 1);
      if (take_a) begin
        send_item(ACT_LOAD, LIST_A, la[ia], 1'b0, '0);
        ia++;
      end else begin
        send_item(ACT_LOAD, LIST_B, lb[ib], 1'b0, '0);
        ib++;
      end
    end
    // Now and then the merge is left out, so the next session loads on top.
    if ($urandom_range(0, 7) != 0) begin
      send_item(ACT_MERGE, 1'($urandom_range(0, 1)), DATA_W'($urandom), 1'b0, '0);
    end
  endtask

  // Receiver stalls: always ready, random, or one cycle in three, switched now and then.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_ALWAYS, RX_EVERY_THIRD);
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    rx_phase = (rx_phase + 1) % 3;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (rx_phase == 0);
    endcase
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    merge_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (merged_expect_q.size() == 0) begin
        $display("%0t: unexpected result, actual value %0d last %0b empty %0b overflow %0b",
                 $time, out_merged_value, out_last, out_empty_res, out_overflow);
        mismatches++;
      end else begin
        exp_r = merged_expect_q.pop_front();
        if (out_merged_value !== exp_r.value) begin
          $display("%0t: merged_value expected %0d, actual %0d",
                   $time, exp_r.value, out_merged_value);
          mismatches++;
        end
        if (out_last !== exp_r.last) begin
          $display("%0t: last expected %0b, actual %0b", $time, exp_r.last, out_last);
          mismatches++;
        end
        if (out_empty_res !== exp_r.empty) begin
          $display("%0t: empty_res expected %0b, actual %0b",
                   $time, exp_r.empty, out_empty_res);
          mismatches++;
        end
        if (out_overflow !== exp_r.ovf) begin
          $display("%0t: overflow expected %0b, actual %0b", $time, exp_r.ovf, out_overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any accepted transaction.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Reset, directed table, random sessions, then drain and report.
  initial begin
    int start_items;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int r = 0; r < DIR_TAB[i].rep; r++) begin
        send_item(DIR_TAB[i].act, DIR_TAB[i].sel, DIR_TAB[i].val,
                  DIR_TAB[i].typed && (r == DIR_TAB[i].rep - 1), DIR_TAB[i].res);
      end
    end
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) run_session();
    send_item(ACT_MERGE, LIST_A, '0, 1'b0, '0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (merged_expect_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
